// ===== rtl/core/wsp_pkg.sv =====
// Shared types and constants for the WAV stream parser.
// Holds parser phase codes, result kinds, status codes, chunk ids and the result record.
// No dependencies.
package wsp_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RIFF  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CHUNK = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FMT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd6;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_IDS   = 4'd1;
    localparam logic [3:0] ST_FMT_SHORT = 4'd2;
    localparam logic [3:0] ST_NO_FMT    = 4'd3;
    localparam logic [3:0] ST_NOT_PCM   = 4'd4;
    localparam logic [3:0] ST_BITS      = 4'd5;
    localparam logic [3:0] ST_RATE      = 4'd6;
    localparam logic [3:0] ST_CHANNELS  = 4'd7;
    localparam logic [3:0] ST_ALIGN     = 4'd8;
    localparam logic [3:0] ST_TRUNC     = 4'd9;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] PCM_BITS       = 16'd16;

    localparam int RATE_W = 18;
    localparam logic [RATE_W-1:0] MIN_RATE_RESET = 18'd8000;
    localparam logic [RATE_W-1:0] MAX_RATE_RESET = 18'd48000;

    localparam logic [1:0] CFG_MIN_RATE = 2'd0;
    localparam logic [1:0] CFG_MAX_RATE = 2'd1;

    // Result queue: room for the two results one byte can cause, plus slack.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam int M_DATA_W = 88;

    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       left;
        logic [15:0]       right;
        logic [RATE_W-1:0] rate;
        logic [1:0]        channels;
        logic [31:0]       size;
        logic [3:0]        status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] vld;    // vld[1] only together with vld[0]
        result_t    r0;
        result_t    r1;
    } result_pair_t;

    function automatic result_t make_closing(input logic [1:0] kind, input logic [3:0] status);
        result_t r;
        r          = '0;
        r.kind     = kind;
        r.status   = status;
        r.last     = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/wsp_parser.sv =====
// Byte-serial RIFF/WAVE parser: header checks, chunk walk, fmt capture, payload pairing.
// Produces up to two results per accepted byte beat. Depends on wsp_pkg.
module wsp_parser import wsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              starts_file,
    input  logic              end_of_file,
    input  logic [RATE_W-1:0] min_rate,
    input  logic [RATE_W-1:0] max_rate,
    output result_pair_t      push
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [4:0]         byte_count_reg, byte_count_next;
    logic [31:0]        shift_word_reg, shift_word_next;
    logic [31:0]        chunk_length_reg, chunk_length_next;
    logic [32:0]        skip_left_reg, skip_left_next;
    logic [15:0]        format_code_reg, format_code_next;
    logic [15:0]        channel_count_reg, channel_count_next;
    logic [31:0]        rate_value_reg, rate_value_next;
    logic [15:0]        sample_bits_reg, sample_bits_next;
    logic [15:0]        align_value_reg, align_value_next;
    logic               fmt_seen_reg, fmt_seen_next;
    logic [31:0]        payload_left_reg, payload_left_next;
    logic [7:0]         low_byte_reg, low_byte_next;
    logic [15:0]        held_left_reg, held_left_next;
    logic [1:0]         frame_pos_reg, frame_pos_next;

    logic [PHASE_W-1:0] ph;
    logic [4:0]         bc;
    logic [4:0]         bc_inc;
    logic               fseen;
    logic [31:0]        sw_new;
    logic [31:0]        size;
    logic [15:0]        sample;
    logic [32:0]        skip_calc;
    logic [31:0]        payload_dec;
    logic               rate_bad;
    result_pair_t       res;

    always_comb begin
        // A file start restarts the parser before this beat is looked at
        ph          = starts_file ? PH_RIFF : phase_reg;
        bc          = starts_file ? 5'd0 : byte_count_reg;
        fseen       = starts_file ? 1'b0 : fmt_seen_reg;
        bc_inc      = bc + 5'd1;
        sw_new      = {data_byte, shift_word_reg[31:8]};
        size        = sw_new;
        sample      = {data_byte, low_byte_reg};
        payload_dec = payload_left_reg - 32'd1;
        rate_bad    = (rate_value_reg < {14'd0, min_rate}) ||
                      (rate_value_reg > {14'd0, max_rate});
        skip_calc   = '0;

        phase_next         = ph;
        byte_count_next    = bc;
        shift_word_next    = shift_word_reg;
        chunk_length_next  = chunk_length_reg;
        skip_left_next     = skip_left_reg;
        format_code_next   = format_code_reg;
        channel_count_next = channel_count_reg;
        rate_value_next    = rate_value_reg;
        sample_bits_next   = sample_bits_reg;
        align_value_next   = align_value_reg;
        fmt_seen_next      = fseen;
        payload_left_next  = payload_left_reg;
        low_byte_next      = low_byte_reg;
        held_left_next     = held_left_reg;
        frame_pos_next     = frame_pos_reg;
        res                = '0;

        if (end_of_file) begin
            if (ph == PH_RIFF || ph == PH_CHUNK || ph == PH_FMT || ph == PH_SKIP) begin
                res.vld    = 2'b01;
                res.r0     = make_closing(KIND_ERROR, ST_TRUNC);
                phase_next = PH_DONE;
            end else if (ph == PH_DATA) begin
                res.vld    = 2'b01;
                res.r0     = make_closing(KIND_END, ST_OK);
                phase_next = PH_DONE;
            end
        end else begin
            unique case (ph)
                PH_RIFF: begin
                    shift_word_next = sw_new;
                    byte_count_next = bc_inc;
                    if (bc_inc == 5'd4) begin
                        chunk_length_next = sw_new;
                    end
                    if (bc_inc == 5'd12) begin
                        if (chunk_length_reg != ID_RIFF || sw_new != ID_WAVE) begin
                            res.vld    = 2'b01;
                            res.r0     = make_closing(KIND_ERROR, ST_BAD_IDS);
                            phase_next = PH_DONE;
                        end else begin
                            byte_count_next   = 5'd0;
                            chunk_length_next = '0;
                            phase_next        = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK: begin
                    shift_word_next = sw_new;
                    byte_count_next = bc_inc;
                    if (bc_inc == 5'd4) begin
                        chunk_length_next = sw_new;
                    end
                    if (bc_inc == 5'd8) begin
                        chunk_length_next = size;
                        byte_count_next   = 5'd0;
                        if (chunk_length_reg == ID_FMT) begin
                            if (size < FMT_BODY_BYTES) begin
                                res.vld    = 2'b01;
                                res.r0     = make_closing(KIND_ERROR, ST_FMT_SHORT);
                                phase_next = PH_DONE;
                            end else begin
                                skip_left_next = {1'b0, size} - {1'b0, FMT_BODY_BYTES}
                                                 + {32'd0, size[0]};
                                phase_next     = PH_FMT;
                            end
                        end else if (chunk_length_reg == ID_DATA) begin
                            res.vld = 2'b01;
                            if (!fseen) begin
                                res.r0     = make_closing(KIND_ERROR, ST_NO_FMT);
                                phase_next = PH_DONE;
                            end else if (format_code_reg != FMT_PCM) begin
                                res.r0     = make_closing(KIND_ERROR, ST_NOT_PCM);
                                phase_next = PH_DONE;
                            end else if (sample_bits_reg != PCM_BITS) begin
                                res.r0     = make_closing(KIND_ERROR, ST_BITS);
                                phase_next = PH_DONE;
                            end else if (rate_bad) begin
                                res.r0     = make_closing(KIND_ERROR, ST_RATE);
                                phase_next = PH_DONE;
                            end else if (channel_count_reg != 16'd1 &&
                                         channel_count_reg != 16'd2) begin
                                res.r0     = make_closing(KIND_ERROR, ST_CHANNELS);
                                phase_next = PH_DONE;
                            end else if (align_value_reg == 16'd0) begin
                                res.r0     = make_closing(KIND_ERROR, ST_ALIGN);
                                phase_next = PH_DONE;
                            end else begin
                                res.r0.kind       = KIND_HEADER;
                                res.r0.rate       = rate_value_reg[RATE_W-1:0];
                                res.r0.channels   = channel_count_reg[1:0];
                                res.r0.size       = size;
                                payload_left_next = size;
                                frame_pos_next    = 2'd0;
                                phase_next        = PH_DATA;
                                // Empty data chunk closes the run right away
                                if (size == 32'd0) begin
                                    res.vld    = 2'b11;
                                    res.r1     = make_closing(KIND_END, ST_OK);
                                    phase_next = PH_DONE;
                                end
                            end
                        end else begin
                            skip_calc      = {1'b0, size} + {32'd0, size[0]};
                            skip_left_next = skip_calc;
                            phase_next     = (skip_calc == 33'd0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    shift_word_next = sw_new;
                    byte_count_next = bc_inc;
                    if (bc_inc == 5'd4) begin
                        format_code_next   = sw_new[15:0];
                        channel_count_next = sw_new[31:16];
                    end else if (bc_inc == 5'd8) begin
                        rate_value_next = sw_new;
                    end else if (bc_inc == 5'd16) begin
                        align_value_next = sw_new[15:0];
                        sample_bits_next = sw_new[31:16];
                        fmt_seen_next    = 1'b1;
                        byte_count_next  = 5'd0;
                        phase_next       = (skip_left_reg == 33'd0) ? PH_CHUNK : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left_next = skip_left_reg - 33'd1;
                    if (skip_left_reg == 33'd1) begin
                        byte_count_next = 5'd0;
                        phase_next      = PH_CHUNK;
                    end
                end
                PH_DATA: begin
                    if (!frame_pos_reg[0]) begin
                        low_byte_next  = data_byte;
                        frame_pos_next = frame_pos_reg + 2'd1;
                    end else if (channel_count_reg == 16'd1) begin
                        res.vld         = 2'b01;
                        res.r0.kind     = KIND_FRAME;
                        res.r0.left     = sample;
                        res.r0.right    = sample;
                        frame_pos_next  = 2'd0;
                    end else if (frame_pos_reg == 2'd1) begin
                        held_left_next  = sample;
                        frame_pos_next  = 2'd2;
                    end else begin
                        res.vld         = 2'b01;
                        res.r0.kind     = KIND_FRAME;
                        res.r0.left     = held_left_reg;
                        res.r0.right    = sample;
                        frame_pos_next  = 2'd0;
                    end
                    payload_left_next = payload_dec;
                    if (payload_dec == 32'd0) begin
                        phase_next = PH_DONE;
                        if (res.vld[0]) begin
                            res.vld = 2'b11;
                            res.r1  = make_closing(KIND_END, ST_OK);
                        end else begin
                            res.vld = 2'b01;
                            res.r0  = make_closing(KIND_END, ST_OK);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        push     = res;
        push.vld = in_fire ? res.vld : 2'b00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            fmt_seen_reg   <= 1'b0;
            frame_pos_reg  <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            fmt_seen_reg   <= fmt_seen_next;
            frame_pos_reg  <= frame_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            shift_word_reg    <= shift_word_next;
            chunk_length_reg  <= chunk_length_next;
            skip_left_reg     <= skip_left_next;
            format_code_reg   <= format_code_next;
            channel_count_reg <= channel_count_next;
            rate_value_reg    <= rate_value_next;
            sample_bits_reg   <= sample_bits_next;
            align_value_reg   <= align_value_next;
            payload_left_reg  <= payload_left_next;
            low_byte_reg      <= low_byte_next;
            held_left_reg     <= held_left_next;
        end
    end

    a_closing_enters_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.vld[0] && (push.r0.last || (push.vld[1] && push.r1.last)))
        |=> phase_reg == PH_DONE)
        else $error("closing result without entering done phase");

    a_frame_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.vld[0] && push.r0.kind == KIND_FRAME) |-> (phase_reg == PH_DATA && !starts_file))
        else $error("frame result outside the data phase");

endmodule

// ===== rtl/core/wsp_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one per beat.
// Depends on wsp_pkg.
module wsp_result_fifo import wsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  result_pair_t push,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      head
);

    result_t              mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_CNT_W-1:0] push_count;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Accept a byte only when both possible results fit
    assign has_room  = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    always_comb begin
        push_count  = RES_CNT_W'(push.vld[0]) + RES_CNT_W'(push.vld[1]);
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + push_count - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.vld[0]) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.vld[1]) begin
            mem_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld[1] |-> push.vld[0])
        else $error("second result pushed without first");

endmodule

// ===== rtl/core/wav_stream_parser_to_stereo.sv =====
// A byte beat's results go through the registered result queue to the master side.
// Throughput: one byte beat per cycle while the result side keeps up; a beat can cause
// up to two results, and the four-entry result queue stalls s_tready when under two free.
// Reset (aresetn, synchronous): parser idle until a file start, queue empty,
// rate limits back to 8000 and 48000 Hz.
module wav_stream_parser_to_stereo import wsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic [1:0]          s_tuser,   // starts_file, end_of_file
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // left_sample, right_sample, rate_hz, channels,
                                           // payload_len, status
    output logic [1:0]          m_tuser,   // result_kind
    output logic                m_tlast,   // last
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [RATE_W-1:0]   cfg_wdata
);

    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;
    logic              in_fire;
    logic              has_room;
    result_pair_t      push;
    result_t           head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rate_reg <= MIN_RATE_RESET;
            max_rate_reg <= MAX_RATE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_RATE: min_rate_reg <= cfg_wdata;
                CFG_MAX_RATE: max_rate_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = has_room;
    assign in_fire  = s_tvalid && s_tready;

    wsp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_tdata),
        .starts_file (s_tuser[0]),
        .end_of_file (s_tuser[1]),
        .min_rate    (min_rate_reg),
        .max_rate    (max_rate_reg),
        .push        (push)
    );

    wsp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {head.status, head.size, head.channels, head.rate,
                      head.right, head.left};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    a_push_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.vld != 2'b00) |-> in_fire)
        else $error("result produced without an accepted beat");

endmodule
